@@ design/cat_pkg.sv @@
// cat_pkg: shared types, codes and sizing constants for the chunk activity tracker
// used by chunk_activity_tracker; depends on nothing else
package cat_pkg;

    // grid and coordinate sizing
    localparam int MAX_GRID_WIDTH  = 64;
    localparam int MAX_GRID_HEIGHT = 64;
    localparam int PIXEL_COORD_MAX = 4095;

    localparam int COORD_W   = 12;
    localparam int CFG_W     = 7;
    localparam int CFG_IDX_W = 2;
    localparam int REM_W     = CFG_W;
    localparam int COL_W     = $clog2(MAX_GRID_WIDTH);
    localparam int ROW_W     = $clog2(MAX_GRID_HEIGHT);
    localparam int DEPTH     = MAX_GRID_WIDTH * MAX_GRID_HEIGHT;
    localparam int ADDR_W    = $clog2(DEPTH);
    localparam int DIV_CNT_W = $clog2(COORD_W);

    // register reset values
    localparam logic [CFG_W-1:0] GRID_WIDTH_RST  = CFG_W'(64);
    localparam logic [CFG_W-1:0] GRID_HEIGHT_RST = CFG_W'(64);
    localparam logic [CFG_W-1:0] CHUNK_SIZE_RST  = CFG_W'(16);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CHUNK_SIZE  = 2'd2;

    // command codes
    localparam logic [2:0] CMD_SIGNAL_CHUNK   = 3'd0;
    localparam logic [2:0] CMD_SIGNAL_PIXEL   = 3'd1;
    localparam logic [2:0] CMD_KEEP_NEIGHBOUR = 3'd2;
    localparam logic [2:0] CMD_QUERY_CHUNK    = 3'd3;
    localparam logic [2:0] CMD_QUERY_PIXEL    = 3'd4;

    // chunk activity codes
    localparam logic [1:0] ST_ASLEEP  = 2'd0;
    localparam logic [1:0] ST_STANDBY = 2'd1;
    localparam logic [1:0] ST_AWAKE   = 2'd2;

    typedef struct packed {
        logic [2:0]         command;
        logic [COORD_W-1:0] coord_x;
        logic [COORD_W-1:0] coord_y;
        logic               signal;
    } cmd_item_t;

    typedef struct packed {
        logic       active;
        logic [1:0] chunk_state;
        logic       out_of_range;
    } rsp_item_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DIV,
        S_CHK,
        S_ADDR,
        S_RD,
        S_MOD,
        S_OUT
    } fsm_state_t;

    typedef enum logic [1:0] {
        OP_HORZ,
        OP_VERT,
        OP_MAIN
    } op_t;

endpackage

@@ design/chunk_activity_tracker.sv @@
// chunk activity tracker: per-chunk state memory with command sequencer and divider
// depends on cat_pkg
//
// Usage:
//   cmd channel (cmd_valid / cmd_stall / cmd_item) carries one command item;
//   rsp channel (rsp_valid / rsp_stall / rsp_item) returns exactly one result
//   item per command. cfg channel (cfg_valid / cfg_ready / cfg_index /
//   cfg_data) writes grid_width, grid_height and chunk_size; cfg_ready is
//   always high, writes are meant to land while no command is in flight.
// Command flow:
//   one command at a time; the next is taken when the previous one has moved
//   into the result register. Chunk-addressed commands pass through check,
//   address, read, modify and result states; pixel commands first run the
//   bit-serial divide by chunk_size, and keep-neighbour adds one read-modify-write
//   of the single-port state memory per woken neighbour. Bad commands go straight
//   to the result state, out-of-grid addresses from the check after any divide.
// Reset:
//   after rst_n is released a clearing pass writes all 4096 entries to asleep,
//   one per cycle; cmd_stall stays high until the pass is over.
// Back pressure:
//   a result waits in the output register while rsp_stall is high; a finished
//   command holds there until the register frees up.

module chunk_activity_tracker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cmd_valid,
    output logic                        cmd_stall,
    input  cat_pkg::cmd_item_t          cmd_item,
    output logic                        rsp_valid,
    input  logic                        rsp_stall,
    output cat_pkg::rsp_item_t          rsp_item,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [cat_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [cat_pkg::CFG_W-1:0]   cfg_data
);

    localparam int PROD_W = cat_pkg::ROW_W + cat_pkg::CFG_W;
    localparam int AREA_W = 2 * cat_pkg::CFG_W;

    // state memory
    logic [1:0] mem [cat_pkg::DEPTH];

    cat_pkg::fsm_state_t state_reg, state_next;
    cat_pkg::op_t        op_reg, op_next;

    logic [cat_pkg::CFG_W-1:0] grid_width_reg, grid_height_reg, chunk_size_reg;
    logic [cat_pkg::CFG_W-1:0] w_eff, h_eff, cs_eff;

    cat_pkg::cmd_item_t item_reg, item_next;
    cat_pkg::rsp_item_t res_reg, res_next;
    cat_pkg::rsp_item_t rsp_item_reg, rsp_item_next;
    logic               rsp_valid_reg, rsp_valid_next;

    logic [cat_pkg::ADDR_W-1:0]    clr_cnt_reg, clr_cnt_next;
    logic [cat_pkg::DIV_CNT_W-1:0] div_cnt_reg, div_cnt_next;
    logic [cat_pkg::COORD_W-1:0]   qx_reg, qx_next, qy_reg, qy_next;
    logic [cat_pkg::REM_W-1:0]     rx_reg, rx_next, ry_reg, ry_next;

    logic [cat_pkg::COL_W-1:0] cx_reg, cx_next, hx_reg, hx_next;
    logic [cat_pkg::ROW_W-1:0] cy_reg, cy_next, vy_reg, vy_next;
    logic                      do_h_reg, do_h_next, do_v_reg, do_v_next;

    logic [cat_pkg::ADDR_W-1:0] addr_reg, addr_next;
    logic [1:0]                 rdata_reg;

    logic                       mem_we, mem_re;
    logic [cat_pkg::ADDR_W-1:0] mem_addr;
    logic [1:0]                 mem_wdata;

    logic                        cmd_fire, is_pixel, is_bad, clr_last, rsp_free;
    logic [cat_pkg::REM_W:0]     trial_x, trial_y;
    logic                        qbit_x, qbit_y, div_last;
    logic [cat_pkg::COORD_W-1:0] cx_full, cy_full;
    logic                        coord_oor;
    logic [cat_pkg::COL_W-1:0]   tgt_x;
    logic [cat_pkg::ROW_W-1:0]   tgt_y;
    logic [PROD_W-1:0]           row_base;
    logic [1:0]                  new_st;
    logic                        main_writes;

    // effective register values
    always_comb
    begin
        if (grid_width_reg == '0)
            w_eff = cat_pkg::CFG_W'(1);
        else if (grid_width_reg > cat_pkg::CFG_W'(cat_pkg::MAX_GRID_WIDTH))
            w_eff = cat_pkg::CFG_W'(cat_pkg::MAX_GRID_WIDTH);
        else
            w_eff = grid_width_reg;

        if (grid_height_reg == '0)
            h_eff = cat_pkg::CFG_W'(1);
        else if (grid_height_reg > cat_pkg::CFG_W'(cat_pkg::MAX_GRID_HEIGHT))
            h_eff = cat_pkg::CFG_W'(cat_pkg::MAX_GRID_HEIGHT);
        else
            h_eff = grid_height_reg;

        cs_eff = (chunk_size_reg == '0) ? cat_pkg::CFG_W'(1) : chunk_size_reg;
    end

    // command decode and handshake terms
    assign cmd_stall = (state_reg != cat_pkg::S_IDLE);
    assign cmd_fire  = cmd_valid && !cmd_stall;
    assign cfg_ready = 1'b1;
    assign rsp_valid = rsp_valid_reg;
    assign rsp_item  = rsp_item_reg;
    assign rsp_free  = !rsp_valid_reg || !rsp_stall;
    assign clr_last  = (clr_cnt_reg == cat_pkg::ADDR_W'(cat_pkg::DEPTH - 1));
    assign div_last  = (div_cnt_reg == cat_pkg::DIV_CNT_W'(cat_pkg::COORD_W - 1));

    assign is_pixel = (item_reg.command == cat_pkg::CMD_SIGNAL_PIXEL)
                   || (item_reg.command == cat_pkg::CMD_KEEP_NEIGHBOUR)
                   || (item_reg.command == cat_pkg::CMD_QUERY_PIXEL);
    assign is_bad   = (cmd_item.command > cat_pkg::CMD_QUERY_PIXEL);

    // one restoring divide step per cycle for both axes
    assign trial_x = {rx_reg, qx_reg[cat_pkg::COORD_W-1]};
    assign trial_y = {ry_reg, qy_reg[cat_pkg::COORD_W-1]};
    assign qbit_x  = (trial_x >= {1'b0, cs_eff});
    assign qbit_y  = (trial_y >= {1'b0, cs_eff});

    // containing chunk and grid check
    assign cx_full   = is_pixel ? qx_reg : item_reg.coord_x;
    assign cy_full   = is_pixel ? qy_reg : item_reg.coord_y;
    assign coord_oor = (is_pixel && ((32'(item_reg.coord_x) > cat_pkg::PIXEL_COORD_MAX)
                                  || (32'(item_reg.coord_y) > cat_pkg::PIXEL_COORD_MAX)))
                    || (cx_full >= cat_pkg::COORD_W'(w_eff))
                    || (cy_full >= cat_pkg::COORD_W'(h_eff));

    // target of the current memory operation
    always_comb
    begin
        unique case (op_reg)
            cat_pkg::OP_HORZ:
            begin
                tgt_x = hx_reg;
                tgt_y = cy_reg;
            end
            cat_pkg::OP_VERT:
            begin
                tgt_x = cx_reg;
                tgt_y = vy_reg;
            end
            default:
            begin
                tgt_x = cx_reg;
                tgt_y = cy_reg;
            end
        endcase
    end

    assign row_base = PROD_W'(tgt_y) * PROD_W'(w_eff);

    // new state of the addressed chunk for signal commands
    assign main_writes = (item_reg.command == cat_pkg::CMD_SIGNAL_CHUNK)
                      || (item_reg.command == cat_pkg::CMD_SIGNAL_PIXEL);
    always_comb
    begin
        if (!main_writes)
            new_st = rdata_reg;
        else if (item_reg.signal)
            new_st = cat_pkg::ST_AWAKE;
        else if (rdata_reg == cat_pkg::ST_AWAKE)
            new_st = cat_pkg::ST_STANDBY;
        else
            new_st = cat_pkg::ST_ASLEEP;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            cat_pkg::S_CLEAR:
                if (clr_last)
                    state_next = cat_pkg::S_IDLE;
            cat_pkg::S_IDLE:
                if (cmd_fire)
                begin
                    if (is_bad)
                        state_next = cat_pkg::S_OUT;
                    else if ((cmd_item.command == cat_pkg::CMD_SIGNAL_CHUNK)
                          || (cmd_item.command == cat_pkg::CMD_QUERY_CHUNK))
                        state_next = cat_pkg::S_CHK;
                    else
                        state_next = cat_pkg::S_DIV;
                end
            cat_pkg::S_DIV:
                if (div_last)
                    state_next = cat_pkg::S_CHK;
            cat_pkg::S_CHK:
                state_next = coord_oor ? cat_pkg::S_OUT : cat_pkg::S_ADDR;
            cat_pkg::S_ADDR:
                state_next = cat_pkg::S_RD;
            cat_pkg::S_RD:
                state_next = cat_pkg::S_MOD;
            cat_pkg::S_MOD:
                state_next = (op_reg == cat_pkg::OP_MAIN) ? cat_pkg::S_OUT : cat_pkg::S_ADDR;
            cat_pkg::S_OUT:
                if (rsp_free)
                    state_next = cat_pkg::S_IDLE;
            default:
                state_next = cat_pkg::S_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb
    begin
        item_next      = item_reg;
        res_next       = res_reg;
        clr_cnt_next   = clr_cnt_reg;
        div_cnt_next   = div_cnt_reg;
        qx_next        = qx_reg;
        qy_next        = qy_reg;
        rx_next        = rx_reg;
        ry_next        = ry_reg;
        cx_next        = cx_reg;
        cy_next        = cy_reg;
        hx_next        = hx_reg;
        vy_next        = vy_reg;
        do_h_next      = do_h_reg;
        do_v_next      = do_v_reg;
        op_next        = op_reg;
        addr_next      = addr_reg;
        rsp_item_next  = rsp_item_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        mem_addr       = addr_reg;
        mem_wdata      = cat_pkg::ST_AWAKE;

        unique case (state_reg)
            cat_pkg::S_CLEAR:
            begin
                mem_we       = 1'b1;
                mem_addr     = clr_cnt_reg;
                mem_wdata    = cat_pkg::ST_ASLEEP;
                clr_cnt_next = clr_cnt_reg + 1'b1;
            end
            cat_pkg::S_IDLE:
                if (cmd_fire)
                begin
                    item_next    = cmd_item;
                    res_next     = '0;
                    div_cnt_next = '0;
                    qx_next      = cmd_item.coord_x;
                    qy_next      = cmd_item.coord_y;
                    rx_next      = '0;
                    ry_next      = '0;
                end
            cat_pkg::S_DIV:
            begin
                rx_next      = qbit_x ? cat_pkg::REM_W'(trial_x - {1'b0, cs_eff})
                                      : trial_x[cat_pkg::REM_W-1:0];
                ry_next      = qbit_y ? cat_pkg::REM_W'(trial_y - {1'b0, cs_eff})
                                      : trial_y[cat_pkg::REM_W-1:0];
                qx_next      = {qx_reg[cat_pkg::COORD_W-2:0], qbit_x};
                qy_next      = {qy_reg[cat_pkg::COORD_W-2:0], qbit_y};
                div_cnt_next = div_cnt_reg + 1'b1;
            end
            cat_pkg::S_CHK:
            begin
                res_next  = '0;
                res_next.out_of_range = coord_oor;
                cx_next   = cx_full[cat_pkg::COL_W-1:0];
                cy_next   = cy_full[cat_pkg::ROW_W-1:0];
                do_h_next = 1'b0;
                do_v_next = 1'b0;
                hx_next   = cx_full[cat_pkg::COL_W-1:0];
                vy_next   = cy_full[cat_pkg::ROW_W-1:0];
                if (item_reg.command == cat_pkg::CMD_KEEP_NEIGHBOUR)
                begin
                    // left edge wins over right, top over bottom
                    if ((rx_reg == '0) && (cx_full != '0))
                    begin
                        do_h_next = 1'b1;
                        hx_next   = cat_pkg::COL_W'(cx_full - 1'b1);
                    end
                    else if ((cat_pkg::CFG_W'(rx_reg) == cs_eff - 1'b1)
                          && ((cx_full + 1'b1) < cat_pkg::COORD_W'(w_eff)))
                    begin
                        do_h_next = 1'b1;
                        hx_next   = cat_pkg::COL_W'(cx_full + 1'b1);
                    end
                    if ((ry_reg == '0) && (cy_full != '0))
                    begin
                        do_v_next = 1'b1;
                        vy_next   = cat_pkg::ROW_W'(cy_full - 1'b1);
                    end
                    else if ((cat_pkg::CFG_W'(ry_reg) == cs_eff - 1'b1)
                          && ((cy_full + 1'b1) < cat_pkg::COORD_W'(h_eff)))
                    begin
                        do_v_next = 1'b1;
                        vy_next   = cat_pkg::ROW_W'(cy_full + 1'b1);
                    end
                end
                if (do_h_next)
                    op_next = cat_pkg::OP_HORZ;
                else if (do_v_next)
                    op_next = cat_pkg::OP_VERT;
                else
                    op_next = cat_pkg::OP_MAIN;
            end
            cat_pkg::S_ADDR:
                addr_next = cat_pkg::ADDR_W'(row_base + PROD_W'(tgt_x));
            cat_pkg::S_RD:
                mem_re = 1'b1;
            cat_pkg::S_MOD:
            begin
                unique case (op_reg)
                    cat_pkg::OP_HORZ:
                    begin
                        mem_we  = 1'b1;
                        op_next = do_v_reg ? cat_pkg::OP_VERT : cat_pkg::OP_MAIN;
                    end
                    cat_pkg::OP_VERT:
                    begin
                        mem_we  = 1'b1;
                        op_next = cat_pkg::OP_MAIN;
                    end
                    default:
                    begin
                        mem_we    = main_writes;
                        mem_wdata = new_st;
                        res_next.active       = (new_st != cat_pkg::ST_ASLEEP);
                        res_next.chunk_state  = new_st;
                        res_next.out_of_range = 1'b0;
                    end
                endcase
            end
            cat_pkg::S_OUT:
                if (rsp_free)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_item_next  = res_reg;
                end
            default:
            begin
            end
        endcase
    end

    // memory: one port, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_addr] <= mem_wdata;
        if (mem_re)
            rdata_reg <= mem[mem_addr];
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= cat_pkg::S_CLEAR;
            clr_cnt_reg     <= '0;
            rsp_valid_reg   <= 1'b0;
            grid_width_reg  <= cat_pkg::GRID_WIDTH_RST;
            grid_height_reg <= cat_pkg::GRID_HEIGHT_RST;
            chunk_size_reg  <= cat_pkg::CHUNK_SIZE_RST;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    cat_pkg::REG_GRID_WIDTH:  grid_width_reg  <= cfg_data;
                    cat_pkg::REG_GRID_HEIGHT: grid_height_reg <= cfg_data;
                    cat_pkg::REG_CHUNK_SIZE:  chunk_size_reg  <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        res_reg      <= res_next;
        rsp_item_reg <= rsp_item_next;
        div_cnt_reg  <= div_cnt_next;
        qx_reg       <= qx_next;
        qy_reg       <= qy_next;
        rx_reg       <= rx_next;
        ry_reg       <= ry_next;
        cx_reg       <= cx_next;
        cy_reg       <= cy_next;
        hx_reg       <= hx_next;
        vy_reg       <= vy_next;
        do_h_reg     <= do_h_next;
        do_v_reg     <= do_v_next;
        op_reg       <= op_next;
        addr_reg     <= addr_next;
    end

    // writes after the clearing pass stay inside the configured grid
    assert property (@(posedge clk) disable iff (!rst_n)
        (mem_we && (state_reg != cat_pkg::S_CLEAR))
            |-> (AREA_W'(mem_addr) < AREA_W'(w_eff) * AREA_W'(h_eff)))
        else $error("state write outside grid");

    // divider remainder stays below the chunk size
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == cat_pkg::S_CHK) && is_pixel)
            |-> (cat_pkg::CFG_W'(rx_reg) < cs_eff) && (cat_pkg::CFG_W'(ry_reg) < cs_eff))
        else $error("divider remainder not below chunk size");

    // an out-of-grid result carries no state
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_item.out_of_range)
            |-> (!rsp_item.active && (rsp_item.chunk_state == cat_pkg::ST_ASLEEP)))
        else $error("out-of-grid result with state");

    // stored states are only the three legal codes
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> ((rsp_item.chunk_state == cat_pkg::ST_ASLEEP)
                    || (rsp_item.chunk_state == cat_pkg::ST_STANDBY)
                    || (rsp_item.chunk_state == cat_pkg::ST_AWAKE)))
        else $error("illegal chunk state reported");

    // a new result is loaded only from the result-ready state
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !$past(rsp_valid)) |-> ($past(state_reg) == cat_pkg::S_OUT))
        else $error("result produced outside result state");

endmodule

@@ bench/testbench.sv @@
// testbench for chunk_activity_tracker: directed table, then randomized command traffic
// checked item by item against a behavioral predictor of the chunk grid
// depends on cat_pkg and chunk_activity_tracker
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    // reserved command codes, which the block must ignore
    localparam logic [2:0] CMD_RSVD5 = 3'd5;
    localparam logic [2:0] CMD_RSVD7 = 3'd7;

    // results that can be typed straight into the table
    localparam cat_pkg::rsp_item_t R_NONE    = {1'b0, cat_pkg::ST_ASLEEP, 1'b0};
    localparam cat_pkg::rsp_item_t R_ASLEEP  = {1'b0, cat_pkg::ST_ASLEEP, 1'b0};
    localparam cat_pkg::rsp_item_t R_STANDBY = {1'b1, cat_pkg::ST_STANDBY, 1'b0};
    localparam cat_pkg::rsp_item_t R_AWAKE   = {1'b1, cat_pkg::ST_AWAKE, 1'b0};
    localparam cat_pkg::rsp_item_t R_OOR     = {1'b0, cat_pkg::ST_ASLEEP, 1'b1};
    // row flag plus empty result: take the predicted result instead
    localparam logic [4:0] USE_PREDICTOR = 5'b0;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int HOLD_CYCLES    = 400;
    localparam int PRESS_PHASE    = 1;
    localparam int PRESS_AT       = 40;
    localparam int PAUSE_PHASE    = 5;
    localparam int PAUSE_AT       = 75;

    typedef struct packed {
        cat_pkg::cmd_item_t item;
        logic               typed;
        cat_pkg::rsp_item_t want;
    } dir_row_t;

    typedef struct packed {
        logic [cat_pkg::CFG_W-1:0] cols;
        logic [cat_pkg::CFG_W-1:0] rows;
        logic [cat_pkg::CFG_W-1:0] side;
        logic [10:0]               items;
        logic                      gaps;
        logic                      shuffled;
    } phase_t;

    // directed rows, run with the reset settings of 64 x 64 chunks of 16 pixels
    localparam int N_DIR = 25;
    localparam dir_row_t DIR_ROWS [N_DIR] = '{
        {cat_pkg::CMD_QUERY_CHUNK,    12'd0,    12'd0,    1'b0, 1'b1, R_ASLEEP},
        {cat_pkg::CMD_QUERY_CHUNK,    12'd63,   12'd63,   1'b0, 1'b1, R_ASLEEP},
        {cat_pkg::CMD_QUERY_CHUNK,    12'd64,   12'd0,    1'b0, 1'b1, R_OOR},
        {cat_pkg::CMD_QUERY_CHUNK,    12'd0,    12'd64,   1'b0, 1'b1, R_OOR},
        {cat_pkg::CMD_QUERY_CHUNK,    12'd4095, 12'd4095, 1'b1, 1'b1, R_OOR},
        {cat_pkg::CMD_SIGNAL_CHUNK,   12'd0,    12'd0,    1'b1, 1'b1, R_AWAKE},
        {cat_pkg::CMD_SIGNAL_CHUNK,   12'd0,    12'd0,    1'b0, 1'b1, R_STANDBY},
        {cat_pkg::CMD_SIGNAL_CHUNK,   12'd0,    12'd0,    1'b0, 1'b1, R_ASLEEP},
        {cat_pkg::CMD_SIGNAL_CHUNK,   12'd0,    12'd0,    1'b0, 1'b1, R_ASLEEP},
        {cat_pkg::CMD_SIGNAL_CHUNK,   12'd64,   12'd3,    1'b1, 1'b1, R_OOR},
        {cat_pkg::CMD_SIGNAL_PIXEL,   12'd1023, 12'd1023, 1'b1, 1'b1, R_AWAKE},
        {cat_pkg::CMD_SIGNAL_PIXEL,   12'd1024, 12'd0,    1'b1, 1'b1, R_OOR},
        {cat_pkg::CMD_SIGNAL_PIXEL,   12'd4095, 12'd4095, 1'b1, 1'b1, R_OOR},
        {cat_pkg::CMD_QUERY_PIXEL,    12'd1023, 12'd1023, 1'b0, 1'b1, R_AWAKE},
        {cat_pkg::CMD_QUERY_PIXEL,    12'd1008, 12'd1008, 1'b0, 1'b1, R_AWAKE},
        // left and top edge: wakes the chunks to the left and above
        {cat_pkg::CMD_KEEP_NEIGHBOUR, 12'd16,   12'd16,   1'b0, USE_PREDICTOR},
        {cat_pkg::CMD_QUERY_CHUNK,    12'd0,    12'd1,    1'b0, USE_PREDICTOR},
        {cat_pkg::CMD_QUERY_CHUNK,    12'd1,    12'd0,    1'b0, USE_PREDICTOR},
        // right and bottom edge
        {cat_pkg::CMD_KEEP_NEIGHBOUR, 12'd31,   12'd31,   1'b1, USE_PREDICTOR},
        {cat_pkg::CMD_QUERY_CHUNK,    12'd1,    12'd2,    1'b0, USE_PREDICTOR},
        // neighbours beyond the grid are skipped without error
        {cat_pkg::CMD_KEEP_NEIGHBOUR, 12'd0,    12'd0,    1'b0, USE_PREDICTOR},
        {cat_pkg::CMD_KEEP_NEIGHBOUR, 12'd1023, 12'd1023, 1'b0, USE_PREDICTOR},
        {cat_pkg::CMD_KEEP_NEIGHBOUR, 12'd8,    12'd4095, 1'b0, 1'b1, R_OOR},
        {CMD_RSVD5,                   12'd4095, 12'd4095, 1'b1, 1'b1, R_NONE},
        {CMD_RSVD7,                   12'd0,    12'd0,    1'b0, 1'b1, R_NONE}
    };

    // register settings per random phase, extremes and out-of-range values included
    localparam int N_PHASES = 9;
    localparam phase_t PHASES [N_PHASES] = '{
        {7'd1,   7'd1,   7'd1,   11'd120, 1'b1, 1'b0},
        {7'd64,  7'd64,  7'd64,  11'd180, 1'b1, 1'b0},
        {7'd0,   7'd0,   7'd0,   11'd100, 1'b1, 1'b0},
        {7'd127, 7'd127, 7'd127, 11'd150, 1'b1, 1'b0},
        {7'd5,   7'd3,   7'd7,   11'd200, 1'b0, 1'b0},
        {7'd64,  7'd1,   7'd2,   11'd150, 1'b1, 1'b0},
        {7'd1,   7'd64,  7'd33,  11'd150, 1'b1, 1'b0},
        {7'd0,   7'd0,   7'd0,   11'd200, 1'b1, 1'b1},
        {7'd64,  7'd64,  7'd16,  11'd180, 1'b0, 1'b0}
    };

    logic                          clk;
    logic                          rst_n     = 1'b0;
    logic                          cmd_valid = 1'b0;
    logic                          cmd_stall;
    cat_pkg::cmd_item_t            cmd_item  = '0;
    logic                          rsp_valid;
    logic                          rsp_stall = 1'b0;
    cat_pkg::rsp_item_t            rsp_item;
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [cat_pkg::CFG_IDX_W-1:0] cfg_index = cat_pkg::REG_GRID_WIDTH;
    logic [cat_pkg::CFG_W-1:0]     cfg_data  = '0;

    // predictor state: chunk grid and register shadows
    logic [1:0]                chunk_grid [cat_pkg::DEPTH];
    logic [cat_pkg::CFG_W-1:0] cfg_width  = cat_pkg::GRID_WIDTH_RST;
    logic [cat_pkg::CFG_W-1:0] cfg_height = cat_pkg::GRID_HEIGHT_RST;
    logic [cat_pkg::CFG_W-1:0] cfg_size   = cat_pkg::CHUNK_SIZE_RST;

    cat_pkg::rsp_item_t chunk_expect_q [$];
    int unsigned        mismatch_count = 0;
    int unsigned        idle_cycles    = 0;
    bit                 gaps_on        = 1'b1;
    bit                 row_typed      = 1'b0;
    cat_pkg::rsp_item_t row_want       = '0;
    int unsigned        hold_reqs      = 0;
    int unsigned        holds_served   = 0;
    int unsigned        stall_left     = 0;

    chunk_activity_tracker u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd_item  (cmd_item),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_item  (rsp_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        foreach (chunk_grid[i])
            chunk_grid[i] = cat_pkg::ST_ASLEEP;
    end

    // effective grid size and chunk side after clamping
    function automatic int unsigned grid_cols();
        if (cfg_width == 0)
            return 1;
        if (cfg_width > cat_pkg::MAX_GRID_WIDTH)
            return cat_pkg::MAX_GRID_WIDTH;
        return cfg_width;
    endfunction

    function automatic int unsigned grid_rows();
        if (cfg_height == 0)
            return 1;
        if (cfg_height > cat_pkg::MAX_GRID_HEIGHT)
            return cat_pkg::MAX_GRID_HEIGHT;
        return cfg_height;
    endfunction

    function automatic int unsigned chunk_side();
        return (cfg_size == 0) ? 1 : cfg_size;
    endfunction

    // one activity signal applied to a chunk
    function automatic void nudge_chunk(input int unsigned cx, input int unsigned cy,
                                        input int unsigned w, input bit wake);
        int unsigned idx;
        idx = cy * w + cx;
        if (wake)
            chunk_grid[idx] = cat_pkg::ST_AWAKE;
        else if (chunk_grid[idx] == cat_pkg::ST_AWAKE)
            chunk_grid[idx] = cat_pkg::ST_STANDBY;
        else
            chunk_grid[idx] = cat_pkg::ST_ASLEEP;
    endfunction

    // updates the grid for one command and returns the result it should give
    function automatic cat_pkg::rsp_item_t predict_chunk_result(input cat_pkg::cmd_item_t it);
        cat_pkg::rsp_item_t r;
        int unsigned        w, h, cs, cx, cy, left, top;
        logic [1:0]         st;
        r = '0;
        w = grid_cols();
        h = grid_rows();
        cs = chunk_side();
        if (it.command > cat_pkg::CMD_QUERY_PIXEL)
            return r;
        if (it.command == cat_pkg::CMD_SIGNAL_CHUNK || it.command == cat_pkg::CMD_QUERY_CHUNK)
        begin
            cx = it.coord_x;
            cy = it.coord_y;
        end
        else
        begin
            if (it.coord_x > cat_pkg::PIXEL_COORD_MAX || it.coord_y > cat_pkg::PIXEL_COORD_MAX)
            begin
                r.out_of_range = 1'b1;
                return r;
            end
            cx = it.coord_x / cs;
            cy = it.coord_y / cs;
        end
        if (cx >= w || cy >= h)
        begin
            r.out_of_range = 1'b1;
            return r;
        end
        if (it.command == cat_pkg::CMD_SIGNAL_CHUNK || it.command == cat_pkg::CMD_SIGNAL_PIXEL)
        begin
            nudge_chunk(cx, cy, w, it.signal);
        end
        else if (it.command == cat_pkg::CMD_KEEP_NEIGHBOUR)
        begin
            // left beats right, top beats bottom
            left = cx * cs;
            top = cy * cs;
            if (it.coord_x == left && cx > 0)
                nudge_chunk(cx - 1, cy, w, 1'b1);
            else if (it.coord_x == left + cs - 1 && cx + 1 < w)
                nudge_chunk(cx + 1, cy, w, 1'b1);
            if (it.coord_y == top && cy > 0)
                nudge_chunk(cx, cy - 1, w, 1'b1);
            else if (it.coord_y == top + cs - 1 && cy + 1 < h)
                nudge_chunk(cx, cy + 1, w, 1'b1);
        end
        st = chunk_grid[cy * w + cx];
        r.active = (st != cat_pkg::ST_ASLEEP);
        r.chunk_state = st;
        return r;
    endfunction

    // pixel inside chunk column or row c, biased toward the chunk edges
    function automatic logic [cat_pkg::COORD_W-1:0] pixel_in(input int unsigned c,
                                                             input int unsigned cs);
        int unsigned off, p;
        case ($urandom_range(0, 3))
            0: off = 0;
            1: off = cs - 1;
            default: off = $urandom_range(0, cs - 1);
        endcase
        p = c * cs + off;
        if (p > cat_pkg::PIXEL_COORD_MAX)
            p = $urandom_range(0, cat_pkg::PIXEL_COORD_MAX);
        return cat_pkg::COORD_W'(p);
    endfunction

    // mostly in-grid commands, some just past the grid, some raw noise
    function automatic cat_pkg::cmd_item_t make_random_command();
        cat_pkg::cmd_item_t it;
        int unsigned        w, h, cs, cx, cy;
        w = grid_cols();
        h = grid_rows();
        cs = chunk_side();
        it = cat_pkg::cmd_item_t'($urandom);
        if ($urandom_range(0, 9) == 0)
            return it;
        it.command = 3'($urandom_range(cat_pkg::CMD_SIGNAL_CHUNK, cat_pkg::CMD_QUERY_PIXEL));
        cx = ($urandom_range(0, 9) == 0) ? $urandom_range(w, w + 2) : $urandom_range(0, w - 1);
        cy = ($urandom_range(0, 9) == 0) ? $urandom_range(h, h + 2) : $urandom_range(0, h - 1);
        if (it.command == cat_pkg::CMD_SIGNAL_CHUNK || it.command == cat_pkg::CMD_QUERY_CHUNK)
        begin
            it.coord_x = cat_pkg::COORD_W'(cx);
            it.coord_y = cat_pkg::COORD_W'(cy);
        end
        else
        begin
            it.coord_x = pixel_in(cx, cs);
            it.coord_y = pixel_in(cy, cs);
        end
        return it;
    endfunction

    task automatic check_field(input string name, input int unsigned want_v,
                               input int unsigned got_v);
        if (want_v != got_v)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want_v, got_v);
            mismatch_count++;
        end
    endtask

    // result side: random stall bursts, plus long hold-offs on request
    always @(negedge clk)
    begin
        if (holds_served != hold_reqs)
        begin
            holds_served = hold_reqs;
            stall_left = HOLD_CYCLES;
        end
        else if (stall_left == 0 && gaps_on && $urandom_range(0, 7) == 0)
        begin
            stall_left = $urandom_range(1, 18);
        end
        if (stall_left != 0)
        begin
            rsp_stall <= 1'b1;
            stall_left--;
        end
        else
        begin
            rsp_stall <= 1'b0;
        end
    end

    // accepted items: check results, predict commands, shadow register writes, watchdog
    always @(posedge clk)
    begin : monitor
        cat_pkg::rsp_item_t want;
        bit                 moved;
        moved = 1'b0;
        if (rsp_valid && !rsp_stall)
        begin
            moved = 1'b1;
            if (chunk_expect_q.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual active %0d state %0d out_of_range %0d",
                         $time, rsp_item.active, rsp_item.chunk_state, rsp_item.out_of_range);
                mismatch_count++;
            end
            else
            begin
                want = chunk_expect_q.pop_front();
                check_field("active", want.active, rsp_item.active);
                check_field("chunk_state", want.chunk_state, rsp_item.chunk_state);
                check_field("out_of_range", want.out_of_range, rsp_item.out_of_range);
            end
        end
        if (cmd_valid && !cmd_stall)
        begin
            moved = 1'b1;
            want = predict_chunk_result(cmd_item);
            if (row_typed)
                want = row_want;
            chunk_expect_q.push_back(want);
        end
        if (cfg_valid && cfg_ready)
        begin
            moved = 1'b1;
            case (cfg_index)
                cat_pkg::REG_GRID_WIDTH:  cfg_width = cfg_data;
                cat_pkg::REG_GRID_HEIGHT: cfg_height = cfg_data;
                cat_pkg::REG_CHUNK_SIZE:  cfg_size = cfg_data;
                default: ;
            endcase
        end
        idle_cycles = moved ? 0 : idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: timeout, no item moved for %0d cycles", $time, idle_cycles);
            $display("Some tests failed");
            $finish;
        end
    end

    // offer one command and hold it until taken; returns at a falling edge
    task automatic send_command(input cat_pkg::cmd_item_t it, input bit typed,
                                input cat_pkg::rsp_item_t want);
        row_typed = typed;
        row_want = want;
        cmd_item <= it;
        cmd_valid <= 1'b1;
        @(posedge clk);
        while (cmd_stall !== 1'b0)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [cat_pkg::CFG_IDX_W-1:0] idx,
                             input logic [cat_pkg::CFG_W-1:0] val);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (cfg_ready !== 1'b1)
            @(posedge clk);
        @(negedge clk);
    endtask

    // drain all results, then rewrite every register
    task automatic reconfigure(input logic [cat_pkg::CFG_W-1:0] cols,
                               input logic [cat_pkg::CFG_W-1:0] rows,
                               input logic [cat_pkg::CFG_W-1:0] side);
        cmd_valid <= 1'b0;
        while (chunk_expect_q.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
        write_reg(cat_pkg::REG_GRID_WIDTH, cols);
        write_reg(cat_pkg::REG_GRID_HEIGHT, rows);
        write_reg(cat_pkg::REG_CHUNK_SIZE, side);
        cfg_valid <= 1'b0;
    endtask

    // main sequence: reset, directed table, random phases, drain
    initial
    begin
        phase_t ph;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int i = 0; i < N_DIR; i++)
            send_command(DIR_ROWS[i].item, DIR_ROWS[i].typed, DIR_ROWS[i].want);

        for (int p = 0; p < N_PHASES; p++)
        begin
            ph = PHASES[p];
            if (ph.shuffled)
            begin
                ph.cols = cat_pkg::CFG_W'($urandom_range(0, 127));
                ph.rows = cat_pkg::CFG_W'($urandom_range(0, 127));
                ph.side = cat_pkg::CFG_W'($urandom_range(0, 127));
            end
            reconfigure(ph.cols, ph.rows, ph.side);
            gaps_on = ph.gaps;
            for (int n = 0; n < ph.items; n++)
            begin
                // receiver holds off while the sender keeps offering
                if (p == PRESS_PHASE && n == PRESS_AT)
                    hold_reqs++;
                if (p == PAUSE_PHASE && n == PAUSE_AT)
                begin
                    cmd_valid <= 1'b0;
                    while (chunk_expect_q.size() != 0)
                        @(negedge clk);
                    @(negedge clk);
                end
                else if (gaps_on && $urandom_range(0, 5) == 0)
                begin
                    cmd_valid <= 1'b0;
                    repeat ($urandom_range(1, 18)) @(negedge clk);
                end
                send_command(make_random_command(), 1'b0, R_NONE);
            end
        end

        cmd_valid <= 1'b0;
        while (chunk_expect_q.size() != 0)
            @(negedge clk);
        repeat (30) @(negedge clk);
        if (mismatch_count == 0 && chunk_expect_q.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

@@ sim.f @@
design/cat_pkg.sv
design/chunk_activity_tracker.sv
bench/testbench.sv
